FILE: rtl/upd_pkg.sv
// Shared types, character constants and the hex digit helper for the URL percent decoder.
// No dependencies.
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int unsigned FIFO_DEPTH = 8;

    // One-hot escape phase.
    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,   // outside an escape
        PH_PCT   = 3'b010,   // '%' seen
        PH_HEX   = 3'b100    // '%' and one more byte seen
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] first_digit;
    } t_esc_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_result;

    // Bit 4 set: not a hex digit; else bits 3:0 hold the value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    function automatic logic [7:0] map_plain(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

FILE: rtl/upd_decode.sv
// Combinational decode of one source beat against the escape state.
// Depends on upd_pkg.
module upd_decode (
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  upd_pkg::t_esc_state i_state,
    output upd_pkg::t_esc_state o_state,
    output logic [1:0]          o_res_cnt,
    output upd_pkg::t_result    o_res0,
    output upd_pkg::t_result    o_res1
);

    logic [4:0] hi;
    logic [4:0] lo;

    assign hi = upd_pkg::hex_value(i_state.first_digit);
    assign lo = upd_pkg::hex_value(i_byte);

    always_comb begin
        o_state.phase       = upd_pkg::PH_PLAIN;
        o_state.first_digit = '0;
        o_res_cnt           = 2'd1;
        o_res0.data         = upd_pkg::map_plain(i_byte);
        o_res0.last         = i_last;
        o_res1.data         = upd_pkg::map_plain(i_byte);
        o_res1.last         = 1'b1;
        case (i_state.phase)
            upd_pkg::PH_PCT: begin
                if (i_last) begin
                    // cut short: literal '%' then the byte
                    o_res_cnt   = 2'd2;
                    o_res0.data = upd_pkg::CH_PERCENT;
                    o_res0.last = 1'b0;
                end else begin
                    o_res_cnt           = 2'd0;
                    o_state.phase       = upd_pkg::PH_HEX;
                    o_state.first_digit = i_byte;
                end
            end
            upd_pkg::PH_HEX: begin
                if (hi[4]) begin
                    o_res0.data = 8'h00;
                end else if (lo[4]) begin
                    o_res0.data = {4'h0, hi[3:0]};
                end else begin
                    o_res0.data = {hi[3:0], lo[3:0]};
                end
            end
            default: begin
                if (i_byte == upd_pkg::CH_PERCENT && !i_last) begin
                    o_res_cnt     = 2'd0;
                    o_state.phase = upd_pkg::PH_PCT;
                end
            end
        endcase
    end

endmodule

FILE: rtl/url_percent_decoder_unit.sv
// URL percent decoder top level: input register, decode, result queue.
// Depends on upd_pkg and upd_decode.
//
// Decodes a form-urlencoded string one source byte per beat: '+' becomes a
// space, '%' plus two bytes becomes one byte read as hex (non-hex first digit
// gives 0, non-hex second digit gives the first digit alone), everything else
// passes through. A string ending one byte after '%' yields '%' then that
// byte; a lone trailing '%' passes through. Each accepted beat gives zero, one
// or two result beats. One beat per cycle is sustained in both directions
// while the result side keeps taking beats: an accepted beat is registered,
// decoded in the next cycle and pushed into a small result queue (FifoDepth
// entries) that drives the output. o_ready depends only on the queue fill,
// so the two sides never meet combinationally; it drops only when the result
// side holds off long enough for the queue to back up.
module url_percent_decoder_unit #(
    parameter int unsigned FifoDepth = upd_pkg::FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
    localparam int unsigned CntW = $clog2(FifoDepth + 1);
    // room for the beat in the input register and the one accepted now
    localparam logic [CntW-1:0] ReadyMax = CntW'(FifoDepth - 4);
    localparam logic [PtrW-1:0] PtrLast  = PtrW'(FifoDepth - 1);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // escape state
    upd_pkg::t_esc_state r_state;
    upd_pkg::t_esc_state dec_state;
    logic [1:0]          dec_cnt;
    upd_pkg::t_result    dec_res0;
    upd_pkg::t_result    dec_res1;

    // result queue
    upd_pkg::t_result r_fifo [FifoDepth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic [PtrW-1:0]  wr_ptr_1;
    logic [PtrW-1:0]  wr_ptr_2;
    logic [PtrW-1:0]  n_rd_ptr;
    logic [CntW-1:0]  n_count;
    logic [1:0]       push_cnt;
    logic             pop;
    logic             in_take;

    assign o_ready = (r_count <= ReadyMax);
    assign in_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    upd_decode u_decode (
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_state   (r_state),
        .o_state   (dec_state),
        .o_res_cnt (dec_cnt),
        .o_res0    (dec_res0),
        .o_res1    (dec_res1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= upd_pkg::PH_PLAIN;
            r_state.first_digit <= '0;
        end else if (r_in_valid) begin
            r_state <= dec_state;
        end
    end

    // queue bookkeeping
    assign push_cnt = r_in_valid ? dec_cnt : 2'd0;
    assign pop      = o_valid && i_ready;
    assign wr_ptr_1 = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + PtrW'(1);
    assign wr_ptr_2 = (wr_ptr_1 == PtrLast) ? '0 : wr_ptr_1 + PtrW'(1);

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + PtrW'(1);
        end
        n_count = r_count + CntW'(push_cnt) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            case (push_cnt)
                2'd1:    r_wr_ptr <= wr_ptr_1;
                2'd2:    r_wr_ptr <= wr_ptr_2;
                default: r_wr_ptr <= r_wr_ptr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= dec_res0;
        end
        if (push_cnt == 2'd2) begin
            r_fifo[wr_ptr_1] <= dec_res1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_byte  = r_fifo[r_rd_ptr].data;
    assign o_last  = r_fifo[r_rd_ptr].last;

    // queue never overfills
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CntW'(FifoDepth)))
        else $error("result queue overflow");

    // a decoded last beat always leaves the escape state clear
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last) |=>
            (r_state.phase == upd_pkg::PH_PLAIN && r_state.first_digit == 8'h00))
        else $error("escape state not cleared after last beat");

    // two results only come from a cut-short escape
    a_two_from_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_cnt == 2'd2) |-> (r_state.phase == upd_pkg::PH_PCT && r_in_last))
        else $error("double result outside a cut-short escape");

endmodule

FILE: tb/tb_url_percent_decoder_unit.sv
// Self-checking bench for url_percent_decoder_unit: random and directed strings in,
// decoded bytes checked against an in-bench decoder. Depends on upd_pkg.
`timescale 1ns / 100ps

module tb_url_percent_decoder_unit;

    // Run shape
    localparam int TAIL_BEATS   = 150;  // last source beats run with no idling
    localparam int PRESSURE_AT  = 300;  // source beats accepted before the long hold
    localparam int HOLD_CYCLES  = 80;   // long receiver hold, well past queue depth
    localparam int DRAIN_CYCLES = 20;   // quiet cycles after the last result
    localparam int STALL_LIMIT  = 2000; // cycles with no beat on either side

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_src_beat;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_byte  = 8'h00;
    logic       i_last  = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_byte;
    logic       o_last;

    url_percent_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_byte  (i_byte),
        .i_last  (i_last),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_byte  (o_byte),
        .o_last  (o_last)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Source beats still to be offered, and decoded bytes still owed by the block
    t_src_beat         pending_chars[$];
    upd_pkg::t_result  decoded_q[$];

    // Bench copy of the decoder state
    upd_pkg::t_phase esc_phase  = upd_pkg::PH_PLAIN;
    logic [7:0]      first_char = 8'h00;

    int accepted_cnt  = 0;
    int total_beats   = 0;
    int mismatch_cnt  = 0;
    int hold_left     = 0;
    bit pressure_done = 1'b0;
    int gap_left      = 0;
    int stall_left    = 0;
    int idle_cycles   = 0;
    t_src_beat next_beat;

    // --------------------------------------------------------------------
    // Decoder model
    // --------------------------------------------------------------------

    // Bit 4 flags a non-digit; letters keep their low nibble, offset by nine.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) begin
            return {1'b0, c[3:0]};
        end
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    task automatic owe_byte(input logic [7:0] v, input logic lst);
        decoded_q.push_back(upd_pkg::t_result'{data: v, last: lst});
    endtask

    // Advance the escape state by one source beat and queue what it yields.
    task automatic decode_char(input logic [7:0] c, input logic lst);
        logic [4:0] hi;
        logic [4:0] lo;
        logic [7:0] v;
        hi = hex_nibble(first_char);
        lo = hex_nibble(c);
        case (esc_phase)
            upd_pkg::PH_PCT: begin
                if (lst) begin
                    // string cut short one byte after '%': '%' then the byte as a plain byte
                    owe_byte(upd_pkg::CH_PERCENT, 1'b0);
                    owe_byte((c == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : c, 1'b1);
                    esc_phase  = upd_pkg::PH_PLAIN;
                    first_char = 8'h00;
                end else begin
                    first_char = c;
                    esc_phase  = upd_pkg::PH_HEX;
                end
            end
            upd_pkg::PH_HEX: begin
                // second byte is always consumed, digit or not
                if (hi[4]) begin
                    v = 8'h00;
                end else if (lo[4]) begin
                    v = {4'h0, hi[3:0]};
                end else begin
                    v = {hi[3:0], lo[3:0]};
                end
                owe_byte(v, lst);
                esc_phase  = upd_pkg::PH_PLAIN;
                first_char = 8'h00;
            end
            default: begin
                if (c == upd_pkg::CH_PERCENT && !lst) begin
                    esc_phase  = upd_pkg::PH_PCT;
                    first_char = 8'h00;
                end else begin
                    // a trailing '%' lands here too and passes straight through
                    owe_byte((c == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : c, lst);
                    esc_phase  = upd_pkg::PH_PLAIN;
                    first_char = 8'h00;
                end
            end
        endcase
    endtask

    task automatic note_fault(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    task automatic compare_decoded(input logic [7:0] got_byte, input logic got_last);
        upd_pkg::t_result want;
        if (decoded_q.size() == 0) begin
            note_fault($sformatf("unexpected result byte=%02h last=%0b", got_byte, got_last));
        end else begin
            want = decoded_q.pop_front();
            if (got_byte !== want.data) begin
                note_fault($sformatf("byte mismatch: expected %02h, got %02h",
                                     want.data, got_byte));
            end
            if (got_last !== want.last) begin
                note_fault($sformatf("last mismatch on byte %02h: expected %0b, got %0b",
                                     want.data, want.last, got_last));
            end
        end
    endtask

    // --------------------------------------------------------------------
    // Stimulus
    // --------------------------------------------------------------------

    task automatic queue_beat(input logic [7:0] c, input logic lst);
        pending_chars.push_back(t_src_beat'{data: c, last: lst});
    endtask

    // Whole string, last flag on its final character.
    task automatic queue_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            queue_beat(s[k], k == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] rand_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    // Random string: well-formed escapes and hex digits so that the escape
    // states see plenty of traffic, with bare '%', '+' and arbitrary bytes mixed in.
    task automatic queue_random_string();
        int len;
        int pick;
        len = $urandom_range(1, 16);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15 && k + 3 <= len) begin
                queue_beat(upd_pkg::CH_PERCENT, 1'b0);
                queue_beat(rand_hex_char(), 1'b0);
                queue_beat(rand_hex_char(), k + 3 == len);
                k += 2;
            end else if (pick < 25) begin
                queue_beat(upd_pkg::CH_PERCENT, k == len - 1);
            end else if (pick < 35) begin
                queue_beat(upd_pkg::CH_PLUS, k == len - 1);
            end else if (pick < 60) begin
                queue_beat(rand_hex_char(), k == len - 1);
            end else begin
                queue_beat(8'($urandom_range(1, 255)), k == len - 1);
            end
        end
    endtask

    // --------------------------------------------------------------------
    // Source side driver
    // --------------------------------------------------------------------
    // A beat is taken when i_valid and o_ready are both high at the edge; the
    // model is advanced there with the payload that was actually presented.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                decode_char(i_byte, i_last);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (i_valid && !o_ready) begin
                // hold payload until taken
            end else if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_chars.size() != 0) begin
                next_beat = pending_chars.pop_front();
                i_byte  <= next_beat.data;
                i_last  <= next_beat.last;
                i_valid <= 1'b1;
                // no gaps in the tail, nor while the receiver is holding off
                if (pending_chars.size() >= TAIL_BEATS && hold_left == 0
                        && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 10);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // --------------------------------------------------------------------
    // Result side monitor
    // --------------------------------------------------------------------
    // Checks each result beat and throttles i_ready. Once, early on, the
    // receiver holds off for a long stretch so the result queue fills and
    // o_ready is forced low while the source keeps offering beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                compare_decoded(o_byte, o_last);
            end
            if (!pressure_done && accepted_cnt >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left <= HOLD_CYCLES;
                i_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (pending_chars.size() >= TAIL_BEATS && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 10);
                end
            end
        end
    end

    // Watchdog: too long without a beat on either side means a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // --------------------------------------------------------------------
    // Stimulus build, reset and end of run
    // --------------------------------------------------------------------
    initial begin
        // Directed: byte extremes, '+', upper/lower hex, bad first or second
        // digit, a '%' as first digit, trailing '%', and strings cut short
        // one byte after '%' (with '+' and with a plain byte).
        queue_text("+");
        queue_beat(8'h01, 1'b1);
        queue_beat(8'hFF, 1'b1);
        queue_text("%41");
        queue_text("%fF");
        queue_text("%aG");
        queue_text("%%1");
        queue_text("%");
        queue_text("%+");
        queue_text("%Z");
        queue_text("a+%30z");
        queue_beat(upd_pkg::CH_PERCENT, 1'b0);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'h01, 1'b1);

        while (pending_chars.size() < 1200) begin
            queue_random_string();
        end
        total_beats = pending_chars.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_cnt == total_beats);
        while (decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        // anything arriving now is an extra result
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: url_percent_decoder_unit.f
rtl/upd_pkg.sv
rtl/upd_decode.sv
rtl/url_percent_decoder_unit.sv
tb/tb_url_percent_decoder_unit.sv
